// ----- design/rse_pkg.sv -----
// Shared types and constants for the subset execute unit.
package rse_pkg;

  localparam int unsigned XLEN        = 64;
  localparam int unsigned OPC_W       = 4;
  localparam int unsigned RIDX_W      = 5;
  localparam int unsigned IMM_W       = 32;
  localparam int unsigned TGT_W       = 10;
  localparam int unsigned LEN_W       = 11;
  localparam int unsigned NPC_OUT_W   = 11;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 88;

  localparam logic [RIDX_W-1:0] X0_IDX = RIDX_W'(0);
  localparam logic [RIDX_W-1:0] X1_IDX = RIDX_W'(1);

  typedef enum logic [OPC_W-1:0] {
    OP_ADDI = 4'd0,
    OP_ADD  = 4'd1,
    OP_LDI  = 4'd2,
    OP_SD   = 4'd3,
    OP_LD   = 4'd4,
    OP_JAL  = 4'd5,
    OP_JALR = 4'd6,
    OP_BEQ  = 4'd7,
    OP_BNE  = 4'd8,
    OP_BLT  = 4'd9,
    OP_NOP  = 4'd10
  } opcode_e;

  // Packed so that opcode sits in the lowest bits, as on the input bus.
  typedef struct packed {
    logic [TGT_W-1:0]        target_index;
    logic signed [IMM_W-1:0] immediate;
    logic [RIDX_W-1:0]       src_reg_b;
    logic [RIDX_W-1:0]       src_reg_a;
    logic [RIDX_W-1:0]       dest_reg;
    logic [OPC_W-1:0]        opcode;
  } instr_t;

  typedef struct packed {
    logic              en;
    logic [RIDX_W-1:0] idx;
    logic [XLEN-1:0]   data;
  } rf_wr_t;

  typedef struct packed {
    logic              fault;
    logic              ld;
    logic [XLEN-1:0]   wval;
    logic [RIDX_W-1:0] rd;
    logic              wr;
  } ex_res_t;

  typedef struct packed {
    logic            st_en;
    logic [XLEN-1:0] addr;
    logic [XLEN-1:0] data;
  } mem_wr_t;

endpackage

// ----- design/rse_regfile.sv -----
// Register file with registered operand reads and write snooping.
module rse_regfile #(
  parameter int unsigned REG_COUNT = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  logic [rse_pkg::RIDX_W-1:0]  addr_a_i,
  input  logic [rse_pkg::RIDX_W-1:0]  addr_b_i,
  input  rse_pkg::rf_wr_t             wr_i,
  output logic [rse_pkg::XLEN-1:0]    opa_o,
  output logic [rse_pkg::XLEN-1:0]    opb_o,
  output logic [rse_pkg::XLEN-1:0]    x1_o
);
  import rse_pkg::*;

  localparam int unsigned RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  logic [XLEN-1:0]      mem_q [REG_COUNT];
  logic [REG_COUNT-1:0] vld_q;
  logic [XLEN-1:0]      opa_q, opb_q, x1_q;
  logic                 a_ok, b_ok;

  assign a_ok = (addr_a_i != X0_IDX) && (32'(addr_a_i) < 32'(REG_COUNT))
                && vld_q[addr_a_i[RW-1:0]];
  assign b_ok = (addr_b_i != X0_IDX) && (32'(addr_b_i) < 32'(REG_COUNT))
                && vld_q[addr_b_i[RW-1:0]];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.idx[RW-1:0]] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      x1_q  <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.idx[RW-1:0]] <= 1'b1;
      if (wr_i.idx == X1_IDX) begin
        x1_q <= wr_i.data;
      end
    end
  end

  // Take the value being written this edge over the stale array contents.
  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.idx == addr_a_i)) begin
      opa_q <= wr_i.data;
    end else if (load_i) begin
      opa_q <= a_ok ? mem_q[addr_a_i[RW-1:0]] : '0;
    end
    if (wr_i.en && (wr_i.idx == addr_b_i)) begin
      opb_q <= wr_i.data;
    end else if (load_i) begin
      opb_q <= b_ok ? mem_q[addr_b_i[RW-1:0]] : '0;
    end
  end

  assign opa_o = opa_q;
  assign opb_o = opb_q;
  assign x1_o  = x1_q;

endmodule

// ----- design/rse_dmem.sv -----
// Data memory with post-reset clearing sweep and registered read.
module rse_dmem #(
  parameter int unsigned MEM_WORDS = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  output logic                      busy_o,
  input  logic                      st_en_i,
  input  logic [$clog2(MEM_WORDS)-1:0] st_addr_i,
  input  logic [rse_pkg::XLEN-1:0]  st_data_i,
  input  logic                      rd_en_i,
  input  logic [$clog2(MEM_WORDS)-1:0] rd_addr_i,
  output logic [rse_pkg::XLEN-1:0]  rd_data_o
);
  import rse_pkg::*;

  localparam int unsigned AW = $clog2(MEM_WORDS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_WORDS - 1);

  logic [XLEN-1:0] mem_q [MEM_WORDS];
  logic [XLEN-1:0] rdata_q;
  logic            clr_busy_q;
  logic [AW-1:0]   clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == LAST_ADDR) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_cnt_q] <= '0;
    end else if (st_en_i) begin
      mem_q[st_addr_i] <= st_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  assign busy_o    = clr_busy_q;
  assign rd_data_o = rdata_q;

endmodule

// ----- design/rse_alu.sv -----
// Execute logic: arithmetic, branch resolution, address checks, next pc.
module rse_alu #(
  parameter int unsigned REG_COUNT = 32,
  parameter int unsigned MEM_WORDS = 256,
  parameter int unsigned PROG_MAX  = 1024
) (
  input  rse_pkg::instr_t                    instr_i,
  input  logic [rse_pkg::XLEN-1:0]           opa_i,
  input  logic [rse_pkg::XLEN-1:0]           opb_i,
  input  logic [rse_pkg::XLEN-1:0]           x1_i,
  input  logic [$clog2(PROG_MAX+1)-1:0]      pc_i,
  input  logic [$clog2(PROG_MAX+1)-1:0]      eff_len_i,
  output rse_pkg::ex_res_t                   res_o,
  output logic [$clog2(PROG_MAX+1)-1:0]      npc_o,
  output logic                               halted_o,
  output rse_pkg::mem_wr_t                   mem_o
);
  import rse_pkg::*;

  localparam int unsigned PC_W = $clog2(PROG_MAX + 1);
  localparam logic [XLEN-1:0] MEM_LIM = XLEN'(MEM_WORDS);
  localparam logic [XLEN-1:0] PC_LIM  = XLEN'(PROG_MAX);
  localparam logic [PC_W-1:0] PC_TOP  = PC_W'(PROG_MAX);

  logic            active, rd_ok, ld_ok, st_ok;
  logic            wr, fault;
  logic [XLEN-1:0] imm64, st_addr, wval, jr_tgt;
  logic [PC_W-1:0] tgt_sat, npc, pc_inc, npc_fin;

  assign active  = pc_i < eff_len_i;
  assign imm64   = {{(XLEN-IMM_W){instr_i.immediate[IMM_W-1]}}, instr_i.immediate};
  assign st_addr = opb_i + imm64;
  assign rd_ok   = (instr_i.dest_reg != X0_IDX)
                   && (32'(instr_i.dest_reg) < 32'(REG_COUNT));
  assign ld_ok   = !opa_i[XLEN-1] && (opa_i < MEM_LIM);
  assign st_ok   = !st_addr[XLEN-1] && (st_addr < MEM_LIM);
  assign pc_inc  = PC_W'(pc_i + 1'b1);
  assign tgt_sat = (XLEN'(instr_i.target_index) > PC_LIM) ? PC_TOP
                                                          : PC_W'(instr_i.target_index);
  // jalr clears its destination before reading x1
  assign jr_tgt  = (instr_i.dest_reg == X1_IDX) ? '0 : x1_i;

  always_comb begin
    wr    = 1'b0;
    wval  = '0;
    fault = 1'b0;
    npc   = pc_inc;
    unique case (opcode_e'(instr_i.opcode))
      OP_ADDI: begin
        wr   = 1'b1;
        wval = opa_i + imm64;
      end
      OP_ADD: begin
        wr   = 1'b1;
        wval = opa_i + opb_i;
      end
      OP_LDI: begin
        wr   = 1'b1;
        wval = imm64;
      end
      OP_SD: begin
        fault = !st_ok;
      end
      OP_LD: begin
        wr    = 1'b1;
        fault = !ld_ok;
      end
      OP_JAL: begin
        wr   = 1'b1;
        wval = XLEN'(pc_i) + XLEN'(1);
        npc  = tgt_sat;
      end
      OP_JALR: begin
        wr = 1'b1;
        if (jr_tgt[XLEN-1]) begin
          fault = 1'b1;
          npc   = PC_TOP;
        end else begin
          npc = (jr_tgt > PC_LIM) ? PC_TOP : PC_W'(jr_tgt);
        end
      end
      OP_BEQ: begin
        if (opa_i == opb_i) npc = tgt_sat;
      end
      OP_BNE: begin
        if (opa_i != imm64) npc = tgt_sat;
      end
      OP_BLT: begin
        if ($signed(opa_i) < $signed(opb_i)) npc = tgt_sat;
      end
      default: begin
      end
    endcase
  end

  assign res_o.wr    = active && wr && rd_ok;
  assign res_o.rd    = res_o.wr ? instr_i.dest_reg : X0_IDX;
  assign res_o.wval  = res_o.wr ? wval : '0;
  assign res_o.ld    = res_o.wr && (instr_i.opcode == OP_LD) && ld_ok;
  assign res_o.fault = active && fault;

  assign npc_fin  = active ? npc : pc_i;
  assign npc_o    = npc_fin;
  assign halted_o = npc_fin >= eff_len_i;

  assign mem_o.st_en = active && (instr_i.opcode == OP_SD) && st_ok;
  assign mem_o.addr  = st_addr;
  assign mem_o.data  = opa_i;

endmodule

// ----- design/riscv_subset_execute_unit.sv -----
// Top level of the subset execute unit: handshake, pipeline registers, pc.
//
// Channel   Direction  Transfer when               Payload
// s_axis    in         tvalid_i & tready_o         one pre-decoded instruction
// m_axis    out        tvalid_o & tready_i         one execution result
// cfg       in         cfg_wr_en_i                 program length
//
// One instruction per cycle sustained while the output is not stalled; a result is
// offered once its input has passed the operand register, then the result
// register. Dependent instructions back to back run at full rate through
// forwarding from the result stage. After reset the data memory is swept to
// zero, one word a cycle over all MEM_WORDS words, while s_axis_tready_o stays
// low. A stalled output holds the result stage; one further instruction is
// still taken into the operand stage.
module riscv_subset_execute_unit #(
  parameter int unsigned REG_COUNT = 32,
  parameter int unsigned MEM_WORDS = 256,
  parameter int unsigned PROG_MAX  = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_wr_en_i,
  input  logic [rse_pkg::LEN_W-1:0]         cfg_wr_data_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // opcode[3:0], dest_reg[8:4], src_reg_a[13:9], src_reg_b[18:14],
  // immediate[50:19], target_index[60:51], zero fill [63:61]
  input  logic [rse_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // write_valid[0], write_reg[5:1], write_value[69:6], next_pc[80:70],
  // halted[81], fault[82], zero fill [87:83]
  output logic [rse_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o
);
  import rse_pkg::*;

  localparam int unsigned PC_W = $clog2(PROG_MAX + 1);
  localparam int unsigned AW   = $clog2(MEM_WORDS);
  localparam int unsigned IW   = $bits(instr_t);

  logic [LEN_W-1:0]     len_q;
  logic [PC_W-1:0]      pc_q, eff_len;
  logic                 s1_valid_q, s2_valid_q;
  instr_t               instr_q, instr_in;
  ex_res_t              s2_res_q, ex_res;
  logic [NPC_OUT_W-1:0] s2_npc_q;
  logic                 s2_halt_q;
  logic                 s2_free, s1_go, accept, clr_busy;
  logic [RIDX_W-1:0]    rf_addr_a, rf_addr_b;
  logic [XLEN-1:0]      opa_raw, opb_raw, x1_raw;
  logic [XLEN-1:0]      opa, opb, x1, s2_val, dm_rdata;
  logic                 s2_pend;
  rf_wr_t               rf_wr;
  mem_wr_t              mem_wr;
  logic [PC_W-1:0]      npc;
  logic                 halted;

  assign instr_in = instr_t'(s_axis_tdata_i[IW-1:0]);

  // Handshake
  assign s2_free         = !s2_valid_q || m_axis_tready_i;
  assign s1_go           = s1_valid_q && s2_free;
  assign s_axis_tready_o = !clr_busy && (!s1_valid_q || s2_free);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cfg_wr_en_i) begin
      len_q <= cfg_wr_data_i;
    end
  end

  assign eff_len = (32'(len_q) > 32'(PROG_MAX)) ? PC_W'(PROG_MAX) : PC_W'(len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      pc_q       <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        s2_valid_q <= 1'b1;
        pc_q       <= npc;
      end else if (m_axis_tready_i) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      instr_q <= instr_in;
    end
    if (s1_go) begin
      s2_res_q  <= ex_res;
      s2_npc_q  <= NPC_OUT_W'(npc);
      s2_halt_q <= halted;
    end
  end

  // Register file: reads follow the incoming item, then hold on the parked one
  assign rf_addr_a = accept ? instr_in.src_reg_a : instr_q.src_reg_a;
  assign rf_addr_b = accept ? instr_in.src_reg_b : instr_q.src_reg_b;

  // Retire the result-stage write as the result transfers
  assign rf_wr.en   = s2_valid_q && m_axis_tready_i && s2_res_q.wr;
  assign rf_wr.idx  = s2_res_q.rd;
  assign rf_wr.data = s2_val;

  rse_regfile #(
    .REG_COUNT (REG_COUNT)
  ) u_regfile (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .addr_a_i (rf_addr_a),
    .addr_b_i (rf_addr_b),
    .wr_i     (rf_wr),
    .opa_o    (opa_raw),
    .opb_o    (opb_raw),
    .x1_o     (x1_raw)
  );

  // Forward the not yet retired result of the instruction ahead
  assign s2_val  = s2_res_q.ld ? dm_rdata : s2_res_q.wval;
  assign s2_pend = s2_valid_q && s2_res_q.wr;
  assign opa = (s2_pend && (s2_res_q.rd == instr_q.src_reg_a)) ? s2_val : opa_raw;
  assign opb = (s2_pend && (s2_res_q.rd == instr_q.src_reg_b)) ? s2_val : opb_raw;
  assign x1  = (s2_pend && (s2_res_q.rd == X1_IDX)) ? s2_val : x1_raw;

  rse_alu #(
    .REG_COUNT (REG_COUNT),
    .MEM_WORDS (MEM_WORDS),
    .PROG_MAX  (PROG_MAX)
  ) u_alu (
    .instr_i   (instr_q),
    .opa_i     (opa),
    .opb_i     (opb),
    .x1_i      (x1),
    .pc_i      (pc_q),
    .eff_len_i (eff_len),
    .res_o     (ex_res),
    .npc_o     (npc),
    .halted_o  (halted),
    .mem_o     (mem_wr)
  );

  rse_dmem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .busy_o    (clr_busy),
    .st_en_i   (s1_go && mem_wr.st_en),
    .st_addr_i (mem_wr.addr[AW-1:0]),
    .st_data_i (mem_wr.data),
    .rd_en_i   (s1_go && (instr_q.opcode == OP_LD)),
    .rd_addr_i (opa[AW-1:0]),
    .rd_data_o (dm_rdata)
  );

  assign m_axis_tdata_o = {
    (OUT_TDATA_W - 83)'(0),
    s2_res_q.fault,
    s2_halt_q,
    s2_npc_q,
    s2_val,
    s2_res_q.rd,
    s2_res_q.wr
  };

endmodule

// ----- verif/tb.sv -----
// Testbench for the subset execute unit: directed and random programs against a predictor.
`timescale 1ns / 1ps

module tb;
  import rse_pkg::*;

  localparam int unsigned REG_COUNT    = 32;
  localparam int unsigned MEM_WORDS    = 256;
  localparam int unsigned PROG_MAX     = 1024;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam logic [OPC_W-1:0] OPC_UNUSED_LO = 4'd11;
  localparam logic [OPC_W-1:0] OPC_UNUSED_HI = 4'd15;

  typedef struct packed {
    logic             write_valid;
    logic [4:0]       write_reg;
    logic [XLEN-1:0]  write_value;
    logic [10:0]      next_pc;
    logic             halted;
    logic             fault;
  } exec_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_en = 1'b0;
  logic [LEN_W-1:0]       cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  // Predictor state
  logic [XLEN-1:0]  reg_model [REG_COUNT];
  logic [XLEN-1:0]  mem_model [MEM_WORDS];
  logic [10:0]      pc_model = '0;
  logic [LEN_W-1:0] length_model = '0;
  exec_result_t     exec_expected [$];

  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_hold_cycles = 0;
  int unsigned rx_gap_left = 0;
  bit          gaps_on = 1'b1;

  riscv_subset_execute_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_wr_en_i     (cfg_en),
    .cfg_wr_data_i   (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: random stall bursts, plus a long hold-off when a test asks for one
  always @(posedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      rx_hold_cycles--;
      m_tready <= 1'b0;
    end else if (rx_gap_left > 0) begin
      rx_gap_left--;
      m_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      rx_gap_left = $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [XLEN-1:0] want,
                             input logic [XLEN-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk_i) begin
    exec_result_t want;
    if (rst_n && m_tvalid && m_tready) begin
      if (exec_expected.size() == 0) begin
        $error("result transfer with nothing outstanding: %0h", m_tdata);
        err_count++;
      end else begin
        want = exec_expected.pop_front();
        check_field("write_valid", XLEN'(want.write_valid), XLEN'(m_tdata[0]));
        check_field("write_reg", XLEN'(want.write_reg), XLEN'(m_tdata[5:1]));
        check_field("write_value", want.write_value, m_tdata[69:6]);
        check_field("next_pc", XLEN'(want.next_pc), XLEN'(m_tdata[80:70]));
        check_field("halted", XLEN'(want.halted), XLEN'(m_tdata[81]));
        check_field("fault", XLEN'(want.fault), XLEN'(m_tdata[82]));
      end
    end
  end

  function automatic logic [10:0] eff_length();
    return (length_model > PROG_MAX) ? 11'(PROG_MAX) : length_model;
  endfunction

  function automatic logic [XLEN-1:0] reg_read(input logic [4:0] idx);
    return (idx == X0_IDX) ? '0 : reg_model[idx];
  endfunction

  function automatic logic [10:0] clamp_target(input logic [XLEN-1:0] t);
    return (t > PROG_MAX) ? 11'(PROG_MAX) : t[10:0];
  endfunction

  task automatic predict_exec(input instr_t ins);
    logic [XLEN-1:0] a, b, imm, addr, wval, t;
    logic [10:0]     npc;
    logic            wr, flt;
    exec_result_t    r;
    a    = reg_read(ins.src_reg_a);
    b    = reg_read(ins.src_reg_b);
    imm  = {{32{ins.immediate[31]}}, ins.immediate};
    npc  = pc_model + 11'd1;
    wr   = 1'b0;
    wval = '0;
    flt  = 1'b0;
    if (pc_model >= eff_length()) begin
      // halted: ignore the instruction, hold the pc
      r = '{1'b0, 5'd0, '0, pc_model, 1'b1, 1'b0};
    end else begin
      case (ins.opcode)
        OP_ADDI: begin wr = 1'b1; wval = a + imm; end
        OP_ADD:  begin wr = 1'b1; wval = a + b; end
        OP_LDI:  begin wr = 1'b1; wval = imm; end
        OP_SD: begin
          addr = b + imm;
          if (!addr[XLEN-1] && addr < MEM_WORDS) mem_model[addr[7:0]] = a;
          else flt = 1'b1;
        end
        OP_LD: begin
          wr = 1'b1;
          if (!a[XLEN-1] && a < MEM_WORDS) wval = mem_model[a[7:0]];
          else flt = 1'b1;
        end
        OP_JAL: begin
          wr   = 1'b1;
          wval = XLEN'(pc_model) + 1;
          npc  = clamp_target(XLEN'(ins.target_index));
        end
        OP_JALR: begin
          // clear rd before reading the link register
          if (ins.dest_reg != X0_IDX) reg_model[ins.dest_reg] = '0;
          t = reg_read(X1_IDX);
          if (t[XLEN-1]) begin
            flt = 1'b1;
            npc = 11'(PROG_MAX);
          end else begin
            npc = clamp_target(t);
          end
          wr = 1'b1;
        end
        OP_BEQ: if (a == b) npc = clamp_target(XLEN'(ins.target_index));
        OP_BNE: if (a != imm) npc = clamp_target(XLEN'(ins.target_index));
        OP_BLT: if ($signed(a) < $signed(b)) npc = clamp_target(XLEN'(ins.target_index));
        default: ;
      endcase
      if (ins.dest_reg == X0_IDX) wr = 1'b0;
      if (wr) reg_model[ins.dest_reg] = wval;
      pc_model      = npc;
      r.write_valid = wr;
      r.write_reg   = wr ? ins.dest_reg : 5'd0;
      r.write_value = wr ? wval : '0;
      r.next_pc     = npc;
      r.halted      = (npc >= eff_length());
      r.fault       = flt;
    end
    exec_expected = {exec_expected, r};
  endtask

  // Offer one instruction and hold it until the transfer; returns in the transfer step
  task automatic issue_instr(input instr_t ins);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, ins};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    predict_exec(ins);
  endtask

  // Drop valid and wait until every outstanding result has come out
  task automatic settle();
    s_tvalid <= 1'b0;
    while (exec_expected.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] len);
    cfg_en   <= 1'b1;
    cfg_data <= len;
    @(posedge clk_i);
    cfg_en       <= 1'b0;
    length_model = len;
  endtask

  function automatic instr_t make_instr(input logic [3:0] op, input logic [4:0] rd,
                                        input logic [4:0] ra, input logic [4:0] rb,
                                        input logic [31:0] imm, input logic [9:0] tgt);
    instr_t ins;
    ins.opcode       = op;
    ins.dest_reg     = rd;
    ins.src_reg_a    = ra;
    ins.src_reg_b    = rb;
    ins.immediate    = imm;
    ins.target_index = tgt;
    return ins;
  endfunction

  // Favour a few low registers so that back-to-back dependencies are common
  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 1) == 0) ? 5'($urandom_range(1, 7)) : 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [31:0] rand_imm();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($urandom_range(0, 300));
      2: return 32'(0 - int'($urandom_range(1, 300)));
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
    endcase
  endfunction

  // Mostly land inside the program so that execution carries on
  function automatic logic [9:0] rand_target();
    if ($urandom_range(0, 6) != 0 && eff_length() > 0)
      return 10'($urandom_range(0, eff_length() - 1));
    return 10'($urandom_range(0, 1023));
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    if ($urandom_range(0, 3) == 0)
      return LEN_W'($urandom_range(pc_model + 1, pc_model + 40));
    return LEN_W'($urandom_range(pc_model + 1, 2047));
  endfunction

  task automatic send_random_item();
    logic [4:0]  rx, ra;
    logic [31:0] imm;
    int          ofs;
    // keep clear of the top of the program space: a fall-through there halts for good
    if (pc_model >= PROG_MAX - 2) begin
      issue_instr(make_instr(OP_JAL, pick_reg(), 0, 0, rand_imm(), rand_target()));
      return;
    end
    rx = 5'($urandom_range(1, 31));
    case ($urandom_range(0, 99)) inside
      [0:11]:  issue_instr(make_instr(OP_LDI, pick_reg(), pick_reg(), pick_reg(), rand_imm(),
                                      10'($urandom)));
      [12:21]: issue_instr(make_instr(OP_ADDI, pick_reg(), pick_reg(), pick_reg(), rand_imm(),
                                      10'($urandom)));
      [22:31]: issue_instr(make_instr(OP_ADD, pick_reg(), pick_reg(), pick_reg(), rand_imm(),
                                      10'($urandom)));
      [32:43]: begin
        if ($urandom_range(0, 9) < 6) begin
          // base into a register, then store around it, edges of memory included
          ofs = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 31))
                                            : int'($urandom_range(0, 255));
          issue_instr(make_instr(OP_LDI, rx, pick_reg(), pick_reg(), 32'(ofs),
                                 10'($urandom)));
          ofs = int'($urandom_range(0, 8)) - 4;
          issue_instr(make_instr(OP_SD, pick_reg(), pick_reg(), rx, 32'(ofs),
                                 10'($urandom)));
        end else begin
          issue_instr(make_instr(OP_SD, pick_reg(), pick_reg(), pick_reg(), rand_imm(),
                                 10'($urandom)));
        end
      end
      [44:55]: begin
        if ($urandom_range(0, 9) < 6) begin
          ofs = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 31))
                                            : int'($urandom_range(0, 263)) - 4;
          issue_instr(make_instr(OP_LDI, rx, pick_reg(), pick_reg(), 32'(ofs),
                                 10'($urandom)));
          issue_instr(make_instr(OP_LD, pick_reg(), rx, pick_reg(), rand_imm(),
                                 10'($urandom)));
        end else begin
          issue_instr(make_instr(OP_LD, pick_reg(), pick_reg(), pick_reg(), rand_imm(),
                                 10'($urandom)));
        end
      end
      [56:63]: issue_instr(make_instr(OP_JAL, pick_reg(), pick_reg(), pick_reg(), rand_imm(),
                                      rand_target()));
      [64:69]: begin
        // load the link register with a target mostly inside the program, then jump through it
        issue_instr(make_instr(OP_LDI, X1_IDX, pick_reg(), pick_reg(),
                               32'(rand_target()), 10'($urandom)));
        issue_instr(make_instr(OP_JALR, pick_reg(), pick_reg(), pick_reg(), rand_imm(),
                               10'($urandom)));
      end
      [70:77]: begin
        ra = pick_reg();
        issue_instr(make_instr(OP_BEQ, pick_reg(), ra,
                               ($urandom_range(0, 1) == 0) ? ra : pick_reg(),
                               rand_imm(), rand_target()));
      end
      [78:85]: begin
        ra  = pick_reg();
        imm = ($urandom_range(0, 1) == 0) ? 32'(reg_read(ra)) : rand_imm();
        issue_instr(make_instr(OP_BNE, pick_reg(), ra, pick_reg(), imm, rand_target()));
      end
      [86:93]: issue_instr(make_instr(OP_BLT, pick_reg(), pick_reg(), pick_reg(), rand_imm(),
                                      rand_target()));
      [94:96]: issue_instr(make_instr(OP_NOP, pick_reg(), pick_reg(), pick_reg(), rand_imm(),
                                      10'($urandom)));
      default: issue_instr(make_instr(4'($urandom_range(OPC_UNUSED_LO, OPC_UNUSED_HI)),
                                      pick_reg(), pick_reg(), pick_reg(), rand_imm(),
                                      10'($urandom)));
    endcase
  endtask

  task automatic test_directed_ops();
    // length is zero out of reset: the first instruction is ignored
    issue_instr(make_instr(OP_NOP, 0, 0, 0, 0, 0));
    settle();
    write_length(11'd2047);
    issue_instr(make_instr(OP_LDI, 5, 0, 0, 32'h7fff_ffff, 0));
    issue_instr(make_instr(OP_LDI, 6, 0, 0, 32'h8000_0000, 0));
    issue_instr(make_instr(OP_ADDI, 7, 6, 0, 32'hffff_ffff, 0));
    issue_instr(make_instr(OP_ADD, 8, 5, 5, 0, 0));
    issue_instr(make_instr(OP_LDI, 0, 0, 0, 32'd123, 0));
    issue_instr(make_instr(OP_LDI, 9, 0, 0, 32'hffff_ffff, 0));
    issue_instr(make_instr(OP_ADD, 10, 9, 9, 0, 0));
    issue_instr(make_instr(OP_ADDI, 11, 9, 0, 32'd1, 0));
    issue_instr(make_instr(OP_SD, 0, 5, 0, 32'd255, 0));
    issue_instr(make_instr(OP_LDI, 13, 0, 0, 32'd255, 0));
    issue_instr(make_instr(OP_LD, 12, 13, 0, 0, 0));
    issue_instr(make_instr(OP_SD, 0, 5, 0, 32'd256, 0));
    issue_instr(make_instr(OP_SD, 0, 6, 9, 32'd0, 0));
    issue_instr(make_instr(OP_LD, 14, 9, 0, 0, 0));
    issue_instr(make_instr(OP_LD, 31, 0, 31, 32'hffff_ffff, 10'h3ff));
    issue_instr(make_instr(OP_BEQ, 0, 5, 5, 0, 10'd40));
    issue_instr(make_instr(OP_BNE, 0, 9, 0, 32'hffff_ffff, 10'd700));
    issue_instr(make_instr(OP_BNE, 0, 0, 0, 32'd1, 10'd512));
    issue_instr(make_instr(OP_BLT, 0, 6, 5, 0, 10'd100));
    issue_instr(make_instr(OP_BLT, 0, 5, 6, 0, 10'd900));
    issue_instr(make_instr(OP_JAL, 1, 0, 0, 0, 10'd300));
    issue_instr(make_instr(OP_JALR, 3, 0, 0, 0, 0));
    issue_instr(make_instr(OPC_UNUSED_LO, 2, 5, 6, 32'h1234_5678, 10'd5));
    issue_instr(make_instr(OPC_UNUSED_HI, 2, 5, 6, 32'h8765_4321, 10'd6));
    issue_instr(make_instr(OP_NOP, 4, 5, 6, 32'hdead_beef, 10'd7));
    settle();
  endtask

  task automatic test_length_settings();
    write_length(11'd0);
    issue_instr(make_instr(OP_ADDI, 2, 5, 0, 32'd1, 0));
    settle();
    // run off the end of a program that ends right after the current pc
    write_length(LEN_W'(pc_model + 1));
    issue_instr(make_instr(OP_LDI, 2, 0, 0, 32'd77, 0));
    issue_instr(make_instr(OP_ADD, 3, 2, 2, 0, 0));
    settle();
    write_length(11'd1024);
    issue_instr(make_instr(OP_JAL, 4, 0, 0, 0, 10'd10));
    settle();
    write_length(11'd1023);
    issue_instr(make_instr(OP_ADD, 4, 4, 4, 0, 0));
    settle();
  endtask

  task automatic test_output_backpressure();
    write_length(11'd2047);
    // hold the result side off while instructions keep coming, then drain
    rx_hold_cycles = 60;
    repeat (12) send_random_item();
    settle();
    repeat (8) send_random_item();
    settle();
  endtask

  task automatic test_random_program(input int unsigned n_items, input bit with_gaps);
    int unsigned sent, phase_left;
    gaps_on = with_gaps;
    sent    = 0;
    while (sent < n_items) begin
      settle();
      write_length(pick_length());
      phase_left = $urandom_range(40, 160);
      while (phase_left > 0 && sent < n_items && pc_model < eff_length()) begin
        send_random_item();
        sent++;
        phase_left--;
      end
    end
    settle();
  endtask

  // Ends execution for good: jalr through a negative or oversized link value
  task automatic test_jalr_escape();
    logic [31:0] link;
    gaps_on = 1'b0;
    write_length(11'd2047);
    issue_instr(make_instr(OP_JAL, 0, 0, 0, 0, 10'd0));
    case ($urandom_range(0, 2))
      0: link = 32'(0 - int'($urandom_range(1, 1000)));
      1: link = 32'(PROG_MAX);
      default: link = 32'($urandom_range(PROG_MAX + 1, 32'h7fff_ffff));
    endcase
    issue_instr(make_instr(OP_LDI, X1_IDX, 0, 0, link, 0));
    issue_instr(make_instr(OP_JALR, 5'($urandom_range(2, 31)), 0, 0, 0, 0));
    repeat (3) issue_instr(make_instr(OP_ADDI, 5, 5, 0, 32'd1, 0));
    settle();
  endtask

  initial begin
    foreach (reg_model[i]) reg_model[i] = '0;
    foreach (mem_model[i]) mem_model[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_directed_ops();
    test_length_settings();
    test_output_backpressure();
    test_random_program(1000, 1'b1);
    test_random_program(160, 1'b0);
    test_jalr_escape();
    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/rse_pkg.sv
design/rse_regfile.sv
design/rse_dmem.sv
design/rse_alu.sv
design/riscv_subset_execute_unit.sv
verif/tb.sv
